// ----- rtl/core/ppu_pkg.sv -----
// types, status codes and helpers for the particle pool update core
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
  localparam logic [1:0] STATUS_ZERO_LIFE = 2'd2;
  localparam logic [1:0] STATUS_SLOT_IDLE = 2'd3;

  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_AGE   = 1'b1;

  localparam logic signed [20:0] POS_MAX = 21'sd524287;
  localparam logic signed [20:0] POS_MIN = -21'sd524288;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [23:0]        colour;
    logic [15:0]        alpha;
    logic [15:0]        life;
    logic [15:0]        radius;
    logic [15:0]        shrink;
    logic [15:0]        fade;
  } rec_t;

  function automatic logic signed [19:0] sat_pos(input logic signed [20:0] v);
    logic signed [19:0] r;
    if (v > POS_MAX) r = POS_MAX[19:0];
    else if (v < POS_MIN) r = POS_MIN[19:0];
    else r = v[19:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/particle_pool_update_core.sv -----
// particle pool update core: slot memories, ager, spawner with divider and free-slot scan
// age: record read on acceptance, aged in the calc step, result registered in the finish step
// spawn: 17-step fade divider, then one slot checked per cycle from slot 0
//   until a free slot is found or the pool is full; a zero lifetime skips both
// reset: sync active-low; afterwards a clearing pass over every entry of the
//   in-use memory holds off input, then one transaction at a time
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_update_core #(
  parameter int ENTRIES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [11:0]        in_slot,
  input  wire logic signed [19:0] in_start_x,
  input  wire logic signed [19:0] in_start_y,
  input  wire logic signed [15:0] in_step_x,
  input  wire logic signed [15:0] in_step_y,
  input  wire logic [23:0]        in_rgb,
  input  wire logic [15:0]        in_opacity,
  input  wire logic [15:0]        in_lifetime,
  input  wire logic [15:0]        in_size,
  input  wire logic [15:0]        in_shrink,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [11:0]             out_slot_used,
  output logic [1:0]              out_status,
  output logic signed [20:0]      out_left,
  output logic signed [20:0]      out_right,
  output logic signed [20:0]      out_top,
  output logic signed [20:0]      out_bottom,
  output logic [23:0]             out_quad_rgb,
  output logic [15:0]             out_quad_alpha,
  output logic                    out_still_alive
);
  import ppu_pkg::*;

  localparam int AW = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_CALC, ST_DIV, ST_SCAN, ST_FIN} state_t;

  state_t        state_r;
  logic          out_valid_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] scan_addr_r;
  logic [AW-1:0] chk_addr_r;
  logic          chk_valid_r;
  logic          cmd_r;
  logic          in_range_r;
  logic          err_r;
  logic [1:0]    status_r;
  logic [11:0]   slot_r;
  rec_t          rec_r;
  logic [16:0]   div_num_r;
  logic [15:0]   div_rem_r;
  logic [16:0]   div_quo_r;
  logic [4:0]    div_cnt_r;

  logic [11:0]          out_slot_r;
  logic [1:0]           out_status_r;
  logic signed [20:0]   out_left_r, out_right_r, out_top_r, out_bottom_r;
  logic [23:0]          out_rgb_r;
  logic [15:0]          out_alpha_r;
  logic                 out_alive_r;

  // slot memories
  rec_t data_mem [ENTRIES];
  logic use_mem  [ENTRIES];
  rec_t rdat_r;
  logic used_r;

  logic [31:0]   slot_w;
  logic [AW-1:0] in_idx;
  logic          in_ok;
  logic          accept;
  logic          fin_go;
  logic [AW-1:0] use_raddr;
  logic          use_we;
  logic [AW-1:0] use_waddr;
  logic          use_wdata;
  logic          data_we;

  logic signed [20:0] sum_x, sum_y;
  logic [16:0]        trial;
  rec_t               aged;

  assign slot_w = {20'd0, in_slot};
  assign in_idx = slot_w[AW-1:0];
  assign in_ok  = slot_w < 32'(ENTRIES);
  assign accept = in_valid && !in_stall;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    use_raddr = (state_r == ST_SCAN) ? scan_addr_r : in_idx;
    use_we    = (state_r == ST_CLR) || (fin_go && !err_r);
    use_waddr = (state_r == ST_CLR) ? clr_addr_r : idx_r;
    use_wdata = (state_r == ST_CLR) ? 1'b0 : (rec_r.life != 16'd0);
    data_we   = fin_go && !err_r;
  end

  always_ff @(posedge clk) begin
    used_r <= use_mem[use_raddr];
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdat_r <= data_mem[in_idx];
    if (data_we) begin
      data_mem[idx_r] <= rec_r;
    end
  end

  // one frame of ageing on the record just read
  always_comb begin
    aged   = rdat_r;
    sum_x  = 21'(rdat_r.pos_x) + 21'(rdat_r.vel_x);
    sum_y  = 21'(rdat_r.pos_y) + 21'(rdat_r.vel_y);
    aged.pos_x  = sat_pos(sum_x);
    aged.pos_y  = sat_pos(sum_y);
    aged.life   = (rdat_r.life != 16'd0) ? rdat_r.life - 16'd1 : 16'd0;
    aged.radius = (rdat_r.radius > rdat_r.shrink) ? rdat_r.radius - rdat_r.shrink : 16'd0;
    aged.alpha  = (rdat_r.alpha > rdat_r.fade) ? rdat_r.alpha - rdat_r.fade : 16'd0;
  end

  assign trial = {div_rem_r, div_num_r[16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
      clr_addr_r  <= '0;
      chk_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r        <= in_command;
            in_range_r   <= in_ok;
            slot_r       <= in_slot;
            idx_r        <= in_idx;
            rec_r.pos_x  <= in_start_x;
            rec_r.pos_y  <= in_start_y;
            rec_r.vel_x  <= in_step_x;
            rec_r.vel_y  <= in_step_y;
            rec_r.colour <= in_rgb;
            rec_r.alpha  <= in_opacity;
            rec_r.life   <= in_lifetime;
            rec_r.radius <= in_size;
            rec_r.shrink <= in_shrink;
            rec_r.fade   <= 16'd0;
            div_num_r    <= 17'h10000 + 17'(in_lifetime[15:1]);
            div_rem_r    <= 16'd0;
            div_quo_r    <= 17'd0;
            div_cnt_r    <= 5'd16;
            if (in_command == CMD_AGE) begin
              state_r <= ST_CALC;
            end else if (in_lifetime == 16'd0) begin
              err_r    <= 1'b1;
              status_r <= STATUS_ZERO_LIFE;
              slot_r   <= 12'd0;
              state_r  <= ST_FIN;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_CALC: begin
          if (in_range_r && used_r) begin
            rec_r    <= aged;
            err_r    <= 1'b0;
            status_r <= STATUS_OK;
          end else begin
            err_r    <= 1'b1;
            status_r <= STATUS_SLOT_IDLE;
          end
          state_r <= ST_FIN;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          div_num_r <= {div_num_r[15:0], 1'b0};
          if (trial >= {1'b0, rec_r.life}) begin
            div_rem_r <= 16'(trial - {1'b0, rec_r.life});
            div_quo_r <= {div_quo_r[15:0], 1'b1};
          end else begin
            div_rem_r <= trial[15:0];
            div_quo_r <= {div_quo_r[15:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 5'd1;
          if (div_cnt_r == 5'd0) begin
            state_r     <= ST_SCAN;
            scan_addr_r <= '0;
            chk_valid_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          // fade saturates when the quotient reaches 65536
          rec_r.fade  <= div_quo_r[16] ? 16'hFFFF : div_quo_r[15:0];
          scan_addr_r <= scan_addr_r + AW'(1);
          chk_addr_r  <= scan_addr_r;
          chk_valid_r <= 1'b1;
          if (chk_valid_r && !used_r) begin
            idx_r       <= chk_addr_r;
            slot_r      <= 12'(chk_addr_r);
            err_r       <= 1'b0;
            status_r    <= STATUS_OK;
            chk_valid_r <= 1'b0;
            state_r     <= ST_FIN;
          end else if (chk_valid_r && chk_addr_r == LAST) begin
            slot_r      <= 12'd0;
            err_r       <= 1'b1;
            status_r    <= STATUS_POOL_FULL;
            chk_valid_r <= 1'b0;
            state_r     <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_slot_r   <= slot_r;
            out_status_r <= status_r;
            if (err_r) begin
              out_left_r   <= '0;
              out_right_r  <= '0;
              out_top_r    <= '0;
              out_bottom_r <= '0;
              out_rgb_r    <= '0;
              out_alpha_r  <= '0;
              out_alive_r  <= 1'b0;
            end else begin
              out_left_r   <= 21'(rec_r.pos_x) - 21'(rec_r.radius);
              out_right_r  <= 21'(rec_r.pos_x) + 21'(rec_r.radius);
              out_top_r    <= 21'(rec_r.pos_y) - 21'(rec_r.radius);
              out_bottom_r <= 21'(rec_r.pos_y) + 21'(rec_r.radius);
              out_rgb_r    <= rec_r.colour;
              out_alpha_r  <= rec_r.alpha;
              out_alive_r  <= (cmd_r == CMD_SPAWN) || (rec_r.life != 16'd0);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_used   = out_slot_r;
  assign out_status      = out_status_r;
  assign out_left        = out_left_r;
  assign out_right       = out_right_r;
  assign out_top         = out_top_r;
  assign out_bottom      = out_bottom_r;
  assign out_quad_rgb    = out_rgb_r;
  assign out_quad_alpha  = out_alpha_r;
  assign out_still_alive = out_alive_r;

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result appeared outside the finish step");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |->
      (out_left_r == 21'sd0 && out_alpha_r == 16'd0 && !out_alive_r))
    else $error("error result carries nonzero fields");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> in_stall)
    else $error("input accepted during clearing pass");

  a_scan_hit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && chk_valid_r && !used_r) |=> (state_r == ST_FIN && !err_r))
    else $error("free slot found but spawn not finished");

endmodule
`default_nettype wire
